// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SMAP_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SMAP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/smap_pkg.sv =====
// Shared types, constants and helpers of the substring matcher.
`timescale 1ns / 1ps
`default_nettype none

package smap_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int TEXT_MAX_DEF    = 4096;

	localparam int LEN_W      = 5;
	localparam int POS_W      = 12;
	localparam int TOTAL_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int FIFO_DEPTH = 8;

	localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;

	localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_PATTERN_LEN  = 2'd2,
		REG_START_POS    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0]      pattern_low;
		logic [63:0]      pattern_high;
		logic [LEN_W-1:0] pattern_length;
		logic [POS_W-1:0] start_floor;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic               is_match;
		logic [TOTAL_W-1:0] total;
		logic               last;
	} result_word_t;

	// Up to two words leave the matcher for one text byte: match first, then end.
	typedef struct packed {
		logic         match_en;
		logic         end_en;
		result_word_t match_word;
		result_word_t end_word;
	} result_push_t;

	// Pick pattern byte idx out of the two 64-bit pattern registers.
	function automatic logic [7:0] pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
		input logic [3:0] idx);
		logic [63:0] sel;
		sel = idx[3] ? hi : lo;
		return sel[{idx[2:0], 3'b000} +: 8];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/substring_match_all_positions.sv =====
// Top level of the streaming substring matcher that reports every match position.
//
//   channel   direction  handshake                  words
//   text      in         text_valid / text_stall    text_byte, text_last
//   result    out        result_valid / result_stall match_position, is_match,
//                                                   match_total, result_last
//   config    in         cfg_write_en               cfg_index, cfg_data
//
// One text byte per cycle while text_stall is low; a byte taken at one edge is compared in
// the next cycle, and its words are then written into the result queue.
// Results leave one per cycle through an 8-word queue while result_stall is low; a byte
// matching on its last position yields two words, so a run of them is held to the output rate.
// text_stall rises when the queue lacks room for two words of the held byte and of the next.
// Reset clears the window, position and count and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module substring_match_all_positions #(
	parameter int PATTERN_MAX = smap_pkg::PATTERN_MAX_DEF,
	parameter int TEXT_MAX    = smap_pkg::TEXT_MAX_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              text_valid,
	output logic                                   text_stall,
	input  wire logic [7:0]                        text_byte,
	input  wire logic                              text_last,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic [smap_pkg::POS_W-1:0]             match_position,
	output logic                                   is_match,
	output logic [smap_pkg::TOTAL_W-1:0]           match_total,
	output logic                                   result_last,
	input  wire logic                              cfg_write_en,
	input  wire logic [smap_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [smap_pkg::CFG_DATA_W-1:0]   cfg_data
);

	smap_pkg::cfg_t         cfg;
	smap_pkg::result_push_t push;
	smap_pkg::result_word_t head;
	logic                   busy_s1;
	logic                   room;
	logic                   text_accept;

	assign text_stall  = !room;
	assign text_accept = text_valid && room;

	smap_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	smap_matcher #(
		.PATTERN_MAX (PATTERN_MAX),
		.TEXT_MAX    (TEXT_MAX)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte),
		.text_last   (text_last),
		.text_accept (text_accept),
		.cfg         (cfg),
		.push        (push),
		.busy_s1     (busy_s1)
	);

	smap_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.pending      (busy_s1),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.head         (head),
		.room         (room)
	);

	// Drive the result word from the queue head
	assign match_position = head.position;
	assign is_match       = head.is_match;
	assign match_total    = head.total;
	assign result_last    = head.last;

endmodule

`default_nettype wire

// ===== hdl/smap_cfg_regs.sv =====
// Configuration register file of the substring matcher.
`timescale 1ns / 1ps
`default_nettype none

module smap_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write_en,
	input  wire logic [smap_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [smap_pkg::CFG_DATA_W-1:0]  cfg_data,
	output smap_pkg::cfg_t                        cfg
);

	smap_pkg::cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low    <= '0;
			cfg_q.pattern_high   <= '0;
			cfg_q.pattern_length <= smap_pkg::LEN_RESET;
			cfg_q.start_floor    <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				smap_pkg::REG_PATTERN_LOW: begin
					cfg_q.pattern_low <= cfg_data;
				end
				smap_pkg::REG_PATTERN_HIGH: begin
					cfg_q.pattern_high <= cfg_data;
				end
				smap_pkg::REG_PATTERN_LEN: begin
					cfg_q.pattern_length <= cfg_data[smap_pkg::LEN_W-1:0];
				end
				smap_pkg::REG_START_POS: begin
					cfg_q.start_floor <= cfg_data[smap_pkg::POS_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/smap_matcher.sv =====
// Input register, byte window and parallel pattern compare.
`timescale 1ns / 1ps
`default_nettype none

module smap_matcher #(
	parameter int PATTERN_MAX = smap_pkg::PATTERN_MAX_DEF,
	parameter int TEXT_MAX    = smap_pkg::TEXT_MAX_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     text_byte,
	input  wire logic           text_last,
	input  wire logic           text_accept,
	input  wire smap_pkg::cfg_t cfg,
	output smap_pkg::result_push_t push,
	output logic                busy_s1
);

	localparam int IW = $clog2(TEXT_MAX + 1);
	localparam int CW = (IW > smap_pkg::POS_W) ? IW : smap_pkg::POS_W;
	localparam int WD = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
	localparam int LW = smap_pkg::LEN_W;
	localparam int TW = smap_pkg::TOTAL_W;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	logic [7:0]    window_q [WD];
	logic [IW-1:0] index_q;
	logic [TW-1:0] count_q;

	logic [LW-1:0] len;
	logic [LW-1:0] len_m1;
	logic          in_range;
	logic          early_ok;
	logic [CW-1:0] start_pos;
	logic [7:0]    cand [PATTERN_MAX];
	logic          bytes_eq;
	logic          hit;
	logic [TW-1:0] count_next;

	// Capture the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= text_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (text_accept) begin
			byte_s1 <= text_byte;
			last_s1 <= text_last;
		end
	end

	// Clamp the pattern length and check position limits
	always_comb begin
		len = (cfg.pattern_length > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : cfg.pattern_length;
		len_m1    = len - LW'(1);
		in_range  = index_q < IW'(TEXT_MAX);
		early_ok  = CW'(index_q) >= CW'(len_m1);
		start_pos = CW'(index_q) - CW'(len_m1);
	end

	// Line up the current byte and the window, newest first
	always_comb begin
		cand[0] = byte_s1;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			cand[k] = window_q[k-1];
		end
	end

	// Compare every used pattern byte in parallel
	always_comb begin
		bytes_eq = 1'b1;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (LW'(k) < len) begin
				if (cand[k] != smap_pkg::pattern_byte(cfg.pattern_low, cfg.pattern_high,
					4'(len_m1 - LW'(k)))) begin
					bytes_eq = 1'b0;
				end
			end
		end
	end

	// Decide on a match and build the result words
	always_comb begin
		hit = valid_s1 && in_range && (len != '0) && early_ok && bytes_eq
			&& (start_pos >= CW'(cfg.start_floor));
		count_next = (hit && (count_q != smap_pkg::COUNT_MAX)) ? count_q + TW'(1) : count_q;

		push.match_en            = hit;
		push.match_word.position = start_pos[smap_pkg::POS_W-1:0];
		push.match_word.is_match = 1'b1;
		push.match_word.total    = count_next;
		push.match_word.last     = 1'b0;

		push.end_en              = valid_s1 && last_s1;
		push.end_word.position   = '0;
		push.end_word.is_match   = 1'b0;
		push.end_word.total      = count_next;
		push.end_word.last       = 1'b1;
	end

	// Advance the window and counters; clear them at end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WD; i++) begin
				window_q[i] <= '0;
			end
			index_q <= '0;
			count_q <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				for (int i = 0; i < WD; i++) begin
					window_q[i] <= '0;
				end
				index_q <= '0;
				count_q <= '0;
			end else begin
				if (in_range) begin
					window_q[0] <= byte_s1;
					for (int i = 1; i < WD; i++) begin
						window_q[i] <= window_q[i-1];
					end
					index_q <= index_q + IW'(1);
				end
				count_q <= count_next;
			end
		end
	end

	assign busy_s1 = valid_s1;

endmodule

`default_nettype wire

// ===== hdl/smap_result_fifo.sv =====
// Result queue that takes up to two words a cycle and hands out one while not stalled.
`timescale 1ns / 1ps
`default_nettype none

module smap_result_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire smap_pkg::result_push_t push,
	input  wire logic                   pending,
	input  wire logic                   result_stall,
	output logic                        result_valid,
	output smap_pkg::result_word_t      head,
	output logic                        room
);

	localparam int DEPTH = smap_pkg::FIFO_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNW   = AW + 2;

	smap_pkg::result_word_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;
	logic [1:0]     n_push;
	logic           pop;
	logic [AW-1:0]  end_ptr;
	logic [CNW-1:0] need;

	always_comb begin
		n_push  = 2'(push.match_en) + 2'(push.end_en);
		pop     = result_valid && !result_stall;
		end_ptr = push.match_en ? wr_ptr_q + AW'(1) : wr_ptr_q;
		// keep room for two words of the held byte and two of the next one
		need    = CNW'(count_q) + (pending ? CNW'(2) : CNW'(0));
		room    = need <= CNW'(DEPTH - 2);
	end

	// Store the match word first, then the end word
	always_ff @(posedge clk) begin
		if (push.match_en) begin
			mem_q[wr_ptr_q] <= push.match_word;
		end
		if (push.end_en) begin
			mem_q[end_ptr] <= push.end_word;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + (AW+1)'(n_push) - (AW+1)'(pop);
		end
	end

	assign result_valid = count_q != '0;
	assign head         = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hdl/smap_checker.sv =====
// Port-level checker of the substring matcher and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module smap_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             result_valid,
	input wire logic                             result_stall,
	input wire logic [smap_pkg::POS_W-1:0]       match_position,
	input wire logic                             is_match,
	input wire logic [smap_pkg::TOTAL_W-1:0]     match_total,
	input wire logic                             result_last
);

	logic                           out_acc;
	logic                           prev_end_q;
	logic [smap_pkg::TOTAL_W-1:0]   prev_total_q;

	assign out_acc = result_valid && !result_stall;

	// Remember the previous delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_end_q   <= 1'b1;
			prev_total_q <= '0;
		end else begin
			if (out_acc) begin
				prev_end_q   <= result_last;
				prev_total_q <= match_total;
			end
		end
	end

	`SMAP_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(match_position) && $stable(match_total) && $stable(is_match) && $stable(result_last), "stalled result word changed")

	`SMAP_ASSERT_IMPLIES(a_kind, clk, arst_n, result_valid, (is_match != result_last) && (!result_last || (match_position == '0)), "result word is neither a clean match nor a clean end")

	`SMAP_ASSERT_IMPLIES(a_first, clk, arst_n, out_acc && is_match && prev_end_q, match_total == smap_pkg::TOTAL_W'(1), "first match of a text does not count one")

	`SMAP_ASSERT_IMPLIES(a_step, clk, arst_n, out_acc && is_match && !prev_end_q && (prev_total_q != smap_pkg::COUNT_MAX), match_total == prev_total_q + smap_pkg::TOTAL_W'(1), "match count did not step by one")

	`SMAP_ASSERT_IMPLIES(a_close, clk, arst_n, out_acc && result_last, match_total == (prev_end_q ? '0 : prev_total_q), "end total differs from last match count")

endmodule

bind substring_match_all_positions smap_checker u_smap_checker (.*);

`default_nettype wire
